// ===== sv/m3i_pkg.sv =====
// Package for the 3x3 matrix inverse: field types, widths, pipeline depths
// and the cofactor product index tables. No dependencies.
`default_nettype none
package m3i_pkg;

    localparam int NE = 9;
    localparam int EW = 16;
    localparam int PW = 2 * EW;
    localparam int AW = PW + 1;
    localparam int DPW = AW + EW;
    localparam int DETW = DPW + 2;
    localparam int DMW = DETW;
    localparam int DW = DMW + 1;
    localparam int QW = 33;
    localparam int NW = 64;
    localparam int TW = 40;
    localparam int OW = 32;
    localparam int SW = 25;

    localparam int FRONT_LAT = 5;
    localparam int LANE_LAT = QW + 2;
    localparam int PIPE_LAT = FRONT_LAT + LANE_LAT;

    localparam logic [TW-1:0] TOL_RESET = TW'(68719);

    typedef logic signed [EW-1:0] t_ent;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [AW-1:0] t_adj;
    typedef logic [DMW-1:0] t_dmag;
    typedef logic signed [OW-1:0] t_res;

    typedef struct packed {
        logic  det_neg;
        t_dmag dmag;
        logic  ok;
    } t_det;

    typedef struct packed {
        t_res res;
        logic ok;
    } t_lane_out;

    typedef int t_idx_tab [NE];

    localparam t_idx_tab PA_I = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam t_idx_tab PA_J = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam t_idx_tab PB_I = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam t_idx_tab PB_J = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage
`default_nettype wire

// ===== sv/m3i_front.sv =====
// Cofactor and determinant front end: adjugate entries, determinant by
// first-row expansion, magnitude and tolerance test. Uses m3i_pkg.
`default_nettype none
module m3i_front import m3i_pkg::*; (
    input  wire logic          i_clk,
    input  wire t_ent          i_a [NE],
    input  wire logic [TW-1:0] i_tol,
    output t_adj               o_adj [NE],
    output t_det               o_det
);

    t_ent  r_a1 [NE];
    t_prod r_pa [NE];
    t_prod r_pb [NE];
    t_ent  r_a2 [3];
    t_adj  r_adj3 [NE];
    t_ent  r_a3 [3];
    logic signed [DPW-1:0] r_dp [3];
    t_adj  r_adj4 [NE];
    t_adj  r_adj5 [NE];
    t_det  r_det5;

    logic signed [DETW-1:0] det;
    t_dmag                  n_dmag;

    always_comb begin
        det = DETW'(r_dp[0]) + DETW'(r_dp[1]) + DETW'(r_dp[2]);
        n_dmag = det[DETW-1] ? t_dmag'(-det) : t_dmag'(det);
    end

    always_ff @(posedge i_clk) begin
        r_a1 <= i_a;
        for (int i = 0; i < NE; i++) begin
            r_pa[i] <= r_a1[PA_I[i]] * r_a1[PA_J[i]];
            r_pb[i] <= r_a1[PB_I[i]] * r_a1[PB_J[i]];
            r_adj3[i] <= AW'(r_pa[i]) - AW'(r_pb[i]);
        end
        for (int i = 0; i < 3; i++) begin
            r_a2[i] <= r_a1[i];
            r_a3[i] <= r_a2[i];
        end
        r_dp[0] <= r_adj3[0] * r_a3[0];
        r_dp[1] <= r_adj3[3] * r_a3[1];
        r_dp[2] <= r_adj3[6] * r_a3[2];
        r_adj4 <= r_adj3;
        r_adj5 <= r_adj4;
        r_det5.det_neg <= det[DETW-1];
        r_det5.dmag <= n_dmag;
        r_det5.ok <= n_dmag > DMW'(i_tol);
    end

    assign o_adj = r_adj5;
    assign o_det = r_det5;

endmodule
`default_nettype wire

// ===== sv/m3i_lane.sv =====
// One division lane: rounded adjugate/determinant quotient, one quotient bit
// per stage, then sign and Q16.16 saturation. Uses m3i_pkg.
`default_nettype none
module m3i_lane import m3i_pkg::*; (
    input  wire logic i_clk,
    input  wire t_adj i_adj,
    input  wire t_det i_det,
    output t_lane_out o_out
);

    logic [DW-1:0]  r_rem [0:QW];
    logic [QW-1:0]  r_low [0:QW];
    logic [QW-1:0]  r_q   [0:QW];
    logic [DW-1:0]  r_d   [0:QW];
    logic [SW-1:0]  r_qs  [0:QW];
    logic           r_sat [0:QW];
    logic           r_negd[0:QW];
    logic           r_negs[0:QW];
    logic           r_ok  [0:QW];
    t_lane_out      r_out;

    logic [OW-1:0]  vm;
    logic [NW-1:0]  num;
    logic [DW-1:0]  d;
    logic [OW:0]    qs_sum;
    logic [QW:0]    mag;
    logic           neg;
    t_res           n_res;

    always_comb begin
        vm = i_adj[AW-1] ? OW'(-i_adj) : OW'(i_adj);
        num = NW'({vm, 29'b0}) + NW'(i_det.dmag);
        d = {i_det.dmag, 1'b0};
        qs_sum = {1'b0, vm} + (OW+1)'(128);
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= DW'(num[NW-1:QW]);
        r_low[0]  <= num[QW-1:0];
        r_q[0]    <= '0;
        r_d[0]    <= d;
        r_qs[0]   <= qs_sum[OW:8];
        r_sat[0]  <= DW'(num[NW-1:QW]) >= d;
        r_negd[0] <= i_adj[AW-1] ^ i_det.det_neg;
        r_negs[0] <= i_adj[AW-1];
        r_ok[0]   <= i_det.ok;
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW:0] t;
        logic        ge;
        assign t  = {r_rem[k], r_low[k][QW-1]};
        assign ge = t >= {1'b0, r_d[k]};
        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= ge ? DW'(t - {1'b0, r_d[k]}) : DW'(t);
            r_low[k+1]  <= {r_low[k][QW-2:0], 1'b0};
            r_q[k+1]    <= {r_q[k][QW-2:0], ge};
            r_d[k+1]    <= r_d[k];
            r_qs[k+1]   <= r_qs[k];
            r_sat[k+1]  <= r_sat[k];
            r_negd[k+1] <= r_negd[k];
            r_negs[k+1] <= r_negs[k];
            r_ok[k+1]   <= r_ok[k];
        end
    end

    always_comb begin
        if (r_ok[QW]) begin
            mag = r_sat[QW] ? '1 : {1'b0, r_q[QW]};
            neg = r_negd[QW] && (mag != '0);
        end else begin
            mag = (QW+1)'(r_qs[QW]);
            neg = r_negs[QW] && (mag != '0);
        end
        if (neg) begin
            n_res = (mag >= (QW+1)'(34'h80000000)) ? t_res'(32'h80000000) : t_res'(-mag);
        end else begin
            n_res = (mag > (QW+1)'(34'h7FFFFFFF)) ? t_res'(32'h7FFFFFFF) : t_res'(mag);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.res <= n_res;
        r_out.ok <= r_ok[QW];
    end

    assign o_out = r_out;

endmodule
`default_nettype wire

// ===== sv/matrix3_inverse.sv =====
// Top level of the 3x3 matrix inverse: tolerance register, cofactor front
// end, nine division lanes and the output merge. Uses m3i_pkg, m3i_front, m3i_lane.
//
// Usage:
//   Input: drive the nine Q4.12 entries with start high; a matrix transfers
//   at every rising edge with start high and busy low. busy is always low,
//   so one matrix may transfer every cycle.
//   Output: o_valid is high for exactly one cycle with the nine Q16.16
//   entries and o_invertible; the receiver cannot stall and must take it.
//   Pipeline: 5 cofactor/determinant stages, 1 lane setup stage, 33
//   quotient-bit stages, 1 saturation stage and 1 merge stage, the first one
//   loaded at the transfer edge; o_valid rises with the merged result.
//   Throughput: one matrix per cycle, set by the nine fully pipelined
//   restoring dividers.
//   Configuration: i_cfg_valid with o_cfg_ready writes det_tolerance; write
//   only while no matrix is in flight. o_cfg_ready is always high.
//   Reset: i_rst_n low synchronously clears the pipeline valid bits and sets
//   det_tolerance to 68719; in-flight matrices are dropped.
`default_nettype none
module matrix3_inverse import m3i_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic signed [15:0] i_a00,
    input  wire logic signed [15:0] i_a01,
    input  wire logic signed [15:0] i_a02,
    input  wire logic signed [15:0] i_a10,
    input  wire logic signed [15:0] i_a11,
    input  wire logic signed [15:0] i_a12,
    input  wire logic signed [15:0] i_a20,
    input  wire logic signed [15:0] i_a21,
    input  wire logic signed [15:0] i_a22,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [39:0]   i_cfg_data,
    output logic               o_valid,
    output logic signed [31:0] o_inv00,
    output logic signed [31:0] o_inv01,
    output logic signed [31:0] o_inv02,
    output logic signed [31:0] o_inv10,
    output logic signed [31:0] o_inv11,
    output logic signed [31:0] o_inv12,
    output logic signed [31:0] o_inv20,
    output logic signed [31:0] o_inv21,
    output logic signed [31:0] o_inv22,
    output logic               o_invertible
);

    logic [TW-1:0]       r_tol;
    logic [PIPE_LAT-1:0] r_vld;
    logic                r_valid;
    t_res                r_res [NE];
    logic                r_inv;

    t_ent      a [NE];
    t_adj      adj [NE];
    t_det      det;
    t_lane_out lane [NE];

    assign busy = 1'b0;
    assign o_cfg_ready = 1'b1;

    assign a[0] = i_a00;
    assign a[1] = i_a01;
    assign a[2] = i_a02;
    assign a[3] = i_a10;
    assign a[4] = i_a11;
    assign a[5] = i_a12;
    assign a[6] = i_a20;
    assign a[7] = i_a21;
    assign a[8] = i_a22;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
            r_vld <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_tol <= i_cfg_data;
            end
            r_vld <= {r_vld[PIPE_LAT-2:0], start && !busy};
            r_valid <= r_vld[PIPE_LAT-1];
        end
    end

    m3i_front u_front (
        .i_clk   (i_clk),
        .i_a     (a),
        .i_tol   (r_tol),
        .o_adj   (adj),
        .o_det   (det)
    );

    for (genvar i = 0; i < NE; i++) begin : g_lane
        m3i_lane u_lane (
            .i_clk   (i_clk),
            .i_adj   (adj[i]),
            .i_det   (det),
            .o_out   (lane[i])
        );
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NE; i++) begin
            r_res[i] <= lane[i].res;
        end
        r_inv <= lane[0].ok;
    end

    assign o_valid = r_valid;
    assign o_inv00 = r_res[0];
    assign o_inv01 = r_res[1];
    assign o_inv02 = r_res[2];
    assign o_inv10 = r_res[3];
    assign o_inv11 = r_res[4];
    assign o_inv12 = r_res[5];
    assign o_inv20 = r_res[6];
    assign o_inv21 = r_res[7];
    assign o_inv22 = r_res[8];
    assign o_invertible = r_inv;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(PIPE_LAT+1) o_valid)
        else $error("transfer produced no result at fixed latency");

    a_sing_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_invertible) |->
            (o_inv00 <= 32'sd8388608 && o_inv00 >= -32'sd8388608 &&
             o_inv11 <= 32'sd8388608 && o_inv11 >= -32'sd8388608 &&
             o_inv22 <= 32'sd8388608 && o_inv22 >= -32'sd8388608))
        else $error("singular result outside adjugate range");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_vld[PIPE_LAT-1]))
        else $error("result strobe without matching transfer");

endmodule
`default_nettype wire
